@@ rtl/core/hpq_pkg.sv @@
`default_nettype none
package hpq_pkg;

  localparam int DATA_W       = 32;
  localparam int COUNT_W      = 7;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 64;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // verdict of the shared compare unit
  typedef struct packed {
    logic take_l;
    logic take_r;
  } pick_t;

endpackage
`default_nettype wire

@@ rtl/core/hpq_mem.sv @@
`default_nettype none
module hpq_mem #(
  parameter int DEPTH = hpq_pkg::CAPACITY_DEF
) (
  input  wire                                  clk,
  input  wire                                  wr_en,
  input  wire  [$clog2(DEPTH)-1:0]             wr_addr,
  input  wire  [hpq_pkg::DATA_W-1:0]           wr_data,
  input  wire  [$clog2(DEPTH)-1:0]             rd_addr_a,
  input  wire  [$clog2(DEPTH)-1:0]             rd_addr_b,
  output logic [hpq_pkg::DATA_W-1:0]           rd_data_a,
  output logic [hpq_pkg::DATA_W-1:0]           rd_data_b
);

  logic [hpq_pkg::DATA_W-1:0] mem [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule
`default_nettype wire

@@ rtl/core/hpq_pick.sv @@
`default_nettype none
module hpq_pick (
  input  wire  signed [hpq_pkg::DATA_W-1:0] cur,
  input  wire  signed [hpq_pkg::DATA_W-1:0] cand_l,
  input  wire                               cand_l_ok,
  input  wire  signed [hpq_pkg::DATA_W-1:0] cand_r,
  input  wire                               cand_r_ok,
  input  wire                               order_min,
  output hpq_pkg::pick_t                    pick
);

  logic signed [hpq_pkg::DATA_W-1:0] best_l;

  // strict compare, ties never win; right only beats the winner of left vs cur
  always_comb begin
    pick.take_l = cand_l_ok && (order_min ? (cand_l < cur) : (cand_l > cur));
    best_l      = pick.take_l ? cand_l : cur;
    pick.take_r = cand_r_ok && (order_min ? (cand_r < best_l) : (cand_r > best_l));
  end

endmodule
`default_nettype wire

@@ rtl/core/binary_heap_priority_queue.sv @@
`default_nettype none
// steps: insert climbs k levels, one parent compare per level, k at most
//   log2(CAPACITY); remove loads root and last element, then sinks k levels (at most
//   log2(CAPACITY)-1); full insert and empty remove go straight to the result, and a
//   remove of the last element skips the sink
// one request at a time, in_stall high until the result registers, longer under out_stall
// reset: synchronous active-low rst_n clears count, order and handshake state, no ram clear
module binary_heap_priority_queue #(
  parameter int CAPACITY = hpq_pkg::CAPACITY_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // request channel
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire                                in_kind,
  input  wire  signed [hpq_pkg::DATA_W-1:0]  in_value,
  // result channel
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic signed [hpq_pkg::DATA_W-1:0]  out_value,
  output logic [hpq_pkg::STATUS_W-1:0]       out_status,
  output logic [hpq_pkg::COUNT_W-1:0]        out_count,
  // order register
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire                                cfg_order_min
);

  localparam int AW = $clog2(CAPACITY);       // ram address
  localparam int CW = $clog2(CAPACITY + 1);   // fill count
  localparam int IW = AW + 2;                 // child index, holds 2*CAPACITY
  localparam int DW = hpq_pkg::DATA_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RM_LD  = 3'd1;
  localparam logic [2:0] S_UP_CMP = 3'd2;
  localparam logic [2:0] S_DN_CMP = 3'd3;
  localparam logic [2:0] S_PUT    = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic order_min_r;
  logic [AW-1:0] pos_r, pos_nxt;
  logic signed [DW-1:0] mov_r, mov_nxt;               // element being sifted
  logic signed [DW-1:0] res_value_r, res_value_nxt;
  logic [hpq_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;

  logic out_valid_r;
  logic signed [DW-1:0] out_value_r;
  logic [hpq_pkg::STATUS_W-1:0] out_status_r;
  logic [hpq_pkg::COUNT_W-1:0] out_count_r;

  // ram side
  logic wr_en;
  logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
  logic [DW-1:0] wr_data, rd_data_a, rd_data_b;

  // compare unit side
  logic signed [DW-1:0] pk_cand_l, pk_cand_r;
  logic pk_l_ok, pk_r_ok, pk_order;
  hpq_pkg::pick_t pick;

  logic in_take;
  logic out_free;
  logic [AW-1:0] parent, grand;
  logic [IW-1:0] left_idx, right_idx, count_ext;
  logic [IW-1:0] nl_idx, nr_idx;
  logic [CW+hpq_pkg::COUNT_W-1:0] count_wide;

  hpq_mem #(
    .DEPTH(CAPACITY)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr_a(rd_addr_a),
    .rd_addr_b(rd_addr_b),
    .rd_data_a(rd_data_a),
    .rd_data_b(rd_data_b)
  );

  hpq_pick u_pick (
    .cur      (mov_r),
    .cand_l   (pk_cand_l),
    .cand_l_ok(pk_l_ok),
    .cand_r   (pk_cand_r),
    .cand_r_ok(pk_r_ok),
    .order_min(pk_order),
    .pick     (pick)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

  // tree index arithmetic
  assign parent    = AW'((pos_r - AW'(1)) >> 1);
  assign grand     = AW'((parent - AW'(1)) >> 1);
  assign left_idx  = {1'b0, pos_r, 1'b1};
  assign right_idx = left_idx + IW'(1);
  assign count_ext = IW'(count_r);
  // children of whichever child wins this cycle
  assign nl_idx = {(pick.take_r ? right_idx[IW-2:0] : left_idx[IW-2:0]), 1'b1};
  assign nr_idx = nl_idx + IW'(1);
  assign count_wide = {{hpq_pkg::COUNT_W{1'b0}}, count_r};

  // compare unit inputs: sift-down picks among children; sift-up asks whether the
  // moving value beats the parent, which is the parent winning under the flipped order
  always_comb begin
    pk_cand_l = rd_data_a;
    pk_cand_r = rd_data_b;
    if (state_r == S_UP_CMP) begin
      pk_l_ok  = 1'b1;
      pk_r_ok  = 1'b0;
      pk_order = !order_min_r;
    end else begin
      pk_l_ok  = (left_idx < count_ext);
      pk_r_ok  = (right_idx < count_ext);
      pk_order = order_min_r;
    end
  end

  // sequencer, one tree level per cycle through the ram read ports and the compare unit
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    mov_nxt        = mov_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    wr_en          = 1'b0;
    wr_addr        = pos_r;
    wr_data        = mov_r;
    rd_addr_a      = parent;
    rd_addr_b      = parent;

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          res_value_nxt  = '0;
          res_status_nxt = hpq_pkg::ST_OK;
          if (in_kind == hpq_pkg::KIND_INSERT) begin
            if (count_r >= CW'(CAPACITY)) begin
              res_status_nxt = hpq_pkg::ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              // new element goes after the last one, parent read starts now
              pos_nxt   = AW'(count_r);
              mov_nxt   = in_value;
              count_nxt = count_r + CW'(1);
              rd_addr_a = AW'((AW'(count_r) - AW'(1)) >> 1);
              state_nxt = (count_r == '0) ? S_PUT : S_UP_CMP;
            end
          end else begin
            if (count_r == '0) begin
              res_value_nxt  = hpq_pkg::VALUE_MIN;
              res_status_nxt = hpq_pkg::ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              // fetch root and last element together
              rd_addr_a = '0;
              rd_addr_b = AW'(count_r - CW'(1));
              count_nxt = count_r - CW'(1);
              state_nxt = S_RM_LD;
            end
          end
        end
      end

      S_RM_LD: begin
        res_value_nxt = rd_data_a;
        mov_nxt       = rd_data_b;
        pos_nxt       = '0;
        rd_addr_a     = AW'(IW'(1));
        rd_addr_b     = AW'(IW'(2));
        state_nxt     = (count_r == '0) ? S_DONE : S_DN_CMP;
      end

      S_UP_CMP: begin
        // rd_data_a holds the parent of pos
        wr_en = 1'b1;
        if (pick.take_l) begin
          wr_data   = rd_data_a;
          pos_nxt   = parent;
          rd_addr_a = grand;
          state_nxt = (parent == '0) ? S_PUT : S_UP_CMP;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DN_CMP: begin
        // rd_data_a / rd_data_b hold the left and right child of pos
        wr_en     = 1'b1;
        rd_addr_a = nl_idx[AW-1:0];
        rd_addr_b = nr_idx[AW-1:0];
        if (pick.take_r) begin
          wr_data = rd_data_b;
          pos_nxt = right_idx[AW-1:0];
        end else if (pick.take_l) begin
          wr_data = rd_data_a;
          pos_nxt = left_idx[AW-1:0];
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_PUT: begin
        wr_en     = 1'b1;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      order_min_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        order_min_r <= cfg_order_min;
      end
      // result register, loaded only when the previous result has gone
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    mov_r        <= mov_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    if (state_r == S_DONE && out_free) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
      out_count_r  <= count_wide[hpq_pkg::COUNT_W-1:0];
    end
  end

endmodule
`default_nettype wire
